@@ rtl/core/bsl_pkg.sv @@
// ----------------------------------------------------------------------------
// bsl_pkg: shared types and constants of the build script lexer
// Token and error codes, scanner modes, character classes, keyword table and
// the helpers that build one result item.
// ----------------------------------------------------------------------------
package bsl_pkg;

   localparam int OFFSET_BITS = 16;
   localparam int LINE_BITS   = 16;
   localparam int FIELD_BITS  = 16;
   localparam int PREFIX_BITS = 56;
   localparam int NUM_KEYWORDS = 8;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_IDENT  = 3'd1,
      MODE_SLASH  = 3'd2,
      MODE_LINE   = 3'd3,
      MODE_BLOCK  = 3'd4,
      MODE_STAR   = 3'd5,
      MODE_STRING = 3'd6
   } scan_mode_type;

   typedef enum logic [4:0] {
      KIND_DOT     = 5'd0,
      KIND_ASSIGN  = 5'd1,
      KIND_LBRACE  = 5'd2,
      KIND_RBRACE  = 5'd3,
      KIND_LPAREN  = 5'd4,
      KIND_RPAREN  = 5'd5,
      KIND_BANG    = 5'd6,
      KIND_STRING  = 5'd7,
      KIND_IDENT   = 5'd8,
      KIND_PROJECT = 5'd9,
      KIND_LIBRARY = 5'd10,
      KIND_STATIC  = 5'd11,
      KIND_DYNAMIC = 5'd12,
      KIND_TRUE    = 5'd13,
      KIND_FALSE   = 5'd14,
      KIND_IF      = 5'd15,
      KIND_ELSE    = 5'd16
   } token_kind_type;

   typedef enum logic [1:0] {
      ERR_NONE          = 2'd0,
      ERR_BAD_CHAR      = 2'd1,
      ERR_OPEN_COMMENT  = 2'd2,
      ERR_OPEN_STRING   = 2'd3
   } error_code_type;

   typedef enum logic [3:0] {
      CLS_NEWLINE,
      CLS_SKIP,
      CLS_HASH,
      CLS_SLASH,
      CLS_QUOTE,
      CLS_PUNCT,
      CLS_NUL,
      CLS_ALPHA,
      CLS_BAD
   } char_class_type;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   localparam logic [PREFIX_BITS-1:0] KEYWORD_TEXT [NUM_KEYWORDS] = '{
      PREFIX_BITS'("Project"), PREFIX_BITS'("Library"), PREFIX_BITS'("static"),
      PREFIX_BITS'("dynamic"), PREFIX_BITS'("true"),    PREFIX_BITS'("false"),
      PREFIX_BITS'("if"),      PREFIX_BITS'("else")
   };

   localparam token_kind_type KEYWORD_KIND [NUM_KEYWORDS] = '{
      KIND_PROJECT, KIND_LIBRARY, KIND_STATIC, KIND_DYNAMIC,
      KIND_TRUE, KIND_FALSE, KIND_IF, KIND_ELSE
   };

   typedef struct packed {
      token_kind_type        kind;
      logic [FIELD_BITS-1:0] start;
      logic [FIELD_BITS-1:0] length;
      logic [FIELD_BITS-1:0] line;
      error_code_type        err;
      logic                  last;
   } rsp_item_type;

   // up to two results leave the scanner per byte
   typedef struct packed {
      logic [1:0]              count;
      rsp_item_type [1:0]      item;
   } scan_push_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
   endfunction

   function automatic logic is_word_char(input logic [7:0] c);
      return is_alpha(c) || (c >= 8'h30 && c <= 8'h39);
   endfunction

   function automatic char_class_type char_class(input logic [7:0] c);
      char_class_type cls;
      case (c) inside
         CH_NL:                                       cls = CLS_NEWLINE;
         CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR,
         CH_SEMI, CH_COMMA:                           cls = CLS_SKIP;
         CH_HASH:                                     cls = CLS_HASH;
         CH_SLASH:                                    cls = CLS_SLASH;
         CH_QUOTE:                                    cls = CLS_QUOTE;
         CH_DOT, CH_EQ, CH_LBRACE, CH_RBRACE,
         CH_LPAREN, CH_RPAREN, CH_BANG:               cls = CLS_PUNCT;
         CH_NUL:                                      cls = CLS_NUL;
         default:                                     cls = is_alpha(c) ? CLS_ALPHA : CLS_BAD;
      endcase
      return cls;
   endfunction

   function automatic token_kind_type punct_kind(input logic [7:0] c);
      token_kind_type kind;
      case (c)
         CH_DOT:    kind = KIND_DOT;
         CH_EQ:     kind = KIND_ASSIGN;
         CH_LBRACE: kind = KIND_LBRACE;
         CH_RBRACE: kind = KIND_RBRACE;
         CH_LPAREN: kind = KIND_LPAREN;
         CH_RPAREN: kind = KIND_RPAREN;
         default:   kind = KIND_BANG;
      endcase
      return kind;
   endfunction

   // shift one character in; a word past seven characters pins to all ones
   function automatic logic [PREFIX_BITS-1:0] add_prefix(input logic [PREFIX_BITS-1:0] p,
                                                         input logic [7:0] c);
      logic [PREFIX_BITS-1:0] r;
      if (p[PREFIX_BITS-1 -: 8] != 8'd0) begin
         r = '1;
      end else begin
         r = {p[PREFIX_BITS-9:0], c};
      end
      return r;
   endfunction

   function automatic token_kind_type word_kind(input logic [PREFIX_BITS-1:0] p);
      token_kind_type kind;
      kind = KIND_IDENT;
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
         if (p == KEYWORD_TEXT[k]) kind = KEYWORD_KIND[k];
      end
      return kind;
   endfunction

   function automatic rsp_item_type make_item(input token_kind_type kind,
                                              input logic [OFFSET_BITS-1:0] start,
                                              input logic [OFFSET_BITS-1:0] length,
                                              input logic [LINE_BITS-1:0] line,
                                              input error_code_type err);
      rsp_item_type r;
      r.kind   = kind;
      r.start  = FIELD_BITS'(start);
      r.length = FIELD_BITS'(length);
      r.line   = FIELD_BITS'(line);
      r.err    = err;
      r.last   = 1'b0;
      return r;
   endfunction

   function automatic rsp_item_type make_word(input logic [PREFIX_BITS-1:0] p,
                                              input logic [OFFSET_BITS-1:0] start,
                                              input logic [OFFSET_BITS-1:0] length,
                                              input logic [LINE_BITS-1:0] line);
      token_kind_type kind;
      rsp_item_type   r;
      kind = word_kind(p);
      if (kind == KIND_IDENT) begin
         r = make_item(kind, start, length, line, ERR_NONE);
      end else begin
         r = make_item(kind, '0, '0, line, ERR_NONE);
      end
      return r;
   endfunction

   function automatic rsp_item_type make_fault(input error_code_type err,
                                               input logic [LINE_BITS-1:0] line);
      return make_item(KIND_DOT, '0, '0, line, err);
   endfunction

endpackage

@@ rtl/core/bsl_scanner.sv @@
// ----------------------------------------------------------------------------
// bsl_scanner: lexer state and per-byte scan
// Holds mode, position, line count and word prefix; turns one accepted byte
// into the next state and up to two result items.
// ----------------------------------------------------------------------------
module bsl_scanner
   import bsl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          fire,
   input  logic [7:0]    text_byte,
   input  logic          end_of_text,
   output scan_push_type push
);

   scan_mode_type          mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] begin_ff, begin_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [LINE_BITS-1:0]   sline_ff, sline_in;
   logic [PREFIX_BITS-1:0] prefix_ff, prefix_in;
   logic                   halted_ff, halted_in;

   logic                   active;
   logic                   ident_end;
   logic                   scan_c;
   logic                   halt_scan;
   logic                   count_nl;
   char_class_type         cls;
   logic [LINE_BITS-1:0]   line_inc;
   scan_push_type          push_v;

   assign active   = fire && !halted_ff;
   assign cls      = char_class(text_byte);
   assign line_inc = (line_ff == '1) ? line_ff : line_ff + LINE_BITS'(1);

   // byte falls through to the normal-mode scan
   always_comb begin
      ident_end = 1'b0;
      unique case (mode_ff)
         MODE_IDENT: begin
            ident_end = !is_word_char(text_byte);
            scan_c    = ident_end;
         end
         MODE_SLASH, MODE_LINE, MODE_BLOCK, MODE_STAR, MODE_STRING: begin
            scan_c = 1'b0;
         end
         default: begin
            scan_c = 1'b1;
         end
      endcase
   end

   // next state
   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      begin_in  = begin_ff;
      sline_in  = sline_ff;
      prefix_in = prefix_ff;
      halt_scan = halted_ff;
      count_nl  = 1'b0;
      if (active) begin
         pos_in = pos_ff + OFFSET_BITS'(1);
         unique case (mode_ff)
            MODE_IDENT: begin
               if (!ident_end) prefix_in = add_prefix(prefix_ff, text_byte);
            end
            MODE_SLASH: begin
               if (text_byte == CH_SLASH) mode_in = MODE_LINE;
               else if (text_byte == CH_STAR) mode_in = MODE_BLOCK;
               else halt_scan = 1'b1;
            end
            MODE_LINE: begin
               if (text_byte == CH_NL) begin
                  count_nl = 1'b1;
                  mode_in  = MODE_NORMAL;
               end
            end
            MODE_BLOCK: begin
               if (text_byte == CH_STAR) mode_in = MODE_STAR;
               else if (text_byte == CH_NL) count_nl = 1'b1;
            end
            MODE_STAR: begin
               if (text_byte == CH_SLASH) begin
                  mode_in = MODE_NORMAL;
               end else if (text_byte != CH_STAR) begin
                  count_nl = (text_byte == CH_NL);
                  mode_in  = MODE_BLOCK;
               end
            end
            MODE_STRING: begin
               if (text_byte == CH_QUOTE) mode_in = MODE_NORMAL;
               else if (text_byte == CH_NL) count_nl = 1'b1;
            end
            default: begin
            end
         endcase
         if (scan_c) begin
            mode_in = MODE_NORMAL;
            case (cls)
               CLS_NEWLINE: count_nl = 1'b1;
               CLS_HASH:    mode_in = MODE_LINE;
               CLS_SLASH: begin
                  mode_in  = MODE_SLASH;
                  sline_in = line_ff;
               end
               CLS_QUOTE: begin
                  mode_in  = MODE_STRING;
                  begin_in = pos_ff + OFFSET_BITS'(1);
                  sline_in = line_ff;
               end
               CLS_ALPHA: begin
                  mode_in   = MODE_IDENT;
                  begin_in  = pos_ff;
                  sline_in  = line_ff;
                  prefix_in = PREFIX_BITS'(text_byte);
               end
               CLS_NUL, CLS_BAD: halt_scan = 1'b1;
               default: begin
               end
            endcase
         end
      end
      line_in   = count_nl ? line_inc : line_ff;
      halted_in = halt_scan || (active && end_of_text);
   end

   // result items
   always_comb begin
      push_v       = '0;
      if (active) begin
         if (ident_end) begin
            push_v.item[push_v.count[0]] = make_word(prefix_ff, begin_ff,
                                                     pos_ff - begin_ff, sline_ff);
            push_v.count = push_v.count + 2'd1;
         end
         if (scan_c && cls == CLS_PUNCT) begin
            push_v.item[push_v.count[0]] = make_item(punct_kind(text_byte), '0, '0,
                                                     line_ff, ERR_NONE);
            push_v.count = push_v.count + 2'd1;
         end
         if (scan_c && cls == CLS_BAD) begin
            push_v.item[push_v.count[0]] = make_fault(ERR_BAD_CHAR, line_ff);
            push_v.count = push_v.count + 2'd1;
         end
         if (mode_ff == MODE_SLASH && text_byte != CH_SLASH && text_byte != CH_STAR) begin
            push_v.item[push_v.count[0]] = make_fault(ERR_BAD_CHAR, sline_ff);
            push_v.count = push_v.count + 2'd1;
         end
         if (mode_ff == MODE_STRING && text_byte == CH_QUOTE) begin
            push_v.item[push_v.count[0]] = make_item(KIND_STRING, begin_ff,
                                                     pos_ff - begin_ff, sline_ff,
                                                     ERR_NONE);
            push_v.count = push_v.count + 2'd1;
         end
         if (end_of_text && !halt_scan) begin
            unique case (mode_in)
               MODE_IDENT: begin
                  push_v.item[push_v.count[0]] = make_word(prefix_in, begin_in,
                                                           pos_in - begin_in, sline_in);
                  push_v.count = push_v.count + 2'd1;
               end
               MODE_SLASH: begin
                  push_v.item[push_v.count[0]] = make_fault(ERR_BAD_CHAR, sline_in);
                  push_v.count = push_v.count + 2'd1;
               end
               MODE_BLOCK, MODE_STAR: begin
                  push_v.item[push_v.count[0]] = make_fault(ERR_OPEN_COMMENT, line_in);
                  push_v.count = push_v.count + 2'd1;
               end
               MODE_STRING: begin
                  push_v.item[push_v.count[0]] = make_fault(ERR_OPEN_STRING, line_in);
                  push_v.count = push_v.count + 2'd1;
               end
               default: begin
               end
            endcase
         end
         if (push_v.count == 2'd2) push_v.item[1].last = 1'b1;
         else if (push_v.count == 2'd1) push_v.item[0].last = 1'b1;
      end
   end

   assign push = push_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NORMAL;
         pos_ff    <= '0;
         begin_ff  <= '0;
         line_ff   <= LINE_BITS'(1);
         sline_ff  <= LINE_BITS'(1);
         prefix_ff <= '0;
         halted_ff <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         begin_ff  <= begin_in;
         line_ff   <= line_in;
         sline_ff  <= sline_in;
         prefix_ff <= prefix_in;
         halted_ff <= halted_in;
      end
   end

endmodule

@@ rtl/core/bsl_rsp_queue.sv @@
// ----------------------------------------------------------------------------
// bsl_rsp_queue: four-entry result queue
// Takes zero, one or two items per cycle and presents the oldest at the head.
// ----------------------------------------------------------------------------
module bsl_rsp_queue
   import bsl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  scan_push_type push,
   output logic          room,
   output logic          head_valid,
   input  logic          head_pop,
   output rsp_item_type  head
);

   localparam int DEPTH = 4;

   rsp_item_type q_ff [DEPTH];
   rsp_item_type q_in [DEPTH];
   logic [2:0]   cnt_ff, cnt_in;
   logic [2:0]   base;
   logic         pop;

   assign pop        = head_pop && (cnt_ff != 3'd0);
   assign base       = cnt_ff - {2'b00, pop};
   assign cnt_in     = base + {1'b0, push.count};
   assign room       = (cnt_ff <= 3'd2);
   assign head_valid = (cnt_ff != 3'd0);
   assign head       = q_ff[0];

   // shift toward the head on a pop, then drop new beats in behind
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         if (3'(i) < base) begin
            q_in[i] = (pop && i < DEPTH - 1) ? q_ff[(i < DEPTH - 1) ? i + 1 : i] : q_ff[i];
         end else if (3'(i) == base && push.count != 2'd0) begin
            q_in[i] = push.item[0];
         end else if (3'(i) == base + 3'd1 && push.count == 2'd2) begin
            q_in[i] = push.item[1];
         end else begin
            q_in[i] = q_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

endmodule

@@ rtl/core/build_script_lexer.sv @@
// ----------------------------------------------------------------------------
// build_script_lexer: streaming lexer for a small build-script language
// Scans source text one byte per beat and emits punctuation, string,
// identifier and keyword tokens, or one error result after which it halts.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+------------------------------------
//   req     | in  | req_tvalid/req_tready  | tdata: text byte; tlast: end of text
//   rsp     | out | rsp_tvalid/rsp_tready  | tdata: start,length,line,error;
//           |     |                        | tuser: token kind; tlast: last of byte
//
// One byte is taken per cycle; the scanner state registers are updated in
// the cycle of the beat and its results (none, one or two) enter a four-entry
// queue. The request side stalls only while that queue holds more than two
// beats; a byte yielding two results needs two result beats, so sustained
// rate is one byte per cycle while results average at most one per byte.
// Synchronous reset returns to line one, offset zero, normal scanning and
// empties the queue. After an error or the end of the text, bytes are still
// taken but dropped until reset.
// ----------------------------------------------------------------------------
module build_script_lexer
   import bsl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [15:0] value_start, [31:16] value_length,
                                    // [47:32] token_line, [49:48] error_code, rest zero
   output logic [4:0]  rsp_tuser,   // [4:0] token_kind
   output logic        rsp_tlast    // last_of_run
);

   logic          fire;
   logic          room;
   scan_push_type push;
   rsp_item_type  head;

   // accept a beat whenever the queue can absorb two results
   assign req_tready = room;
   assign fire       = req_tvalid && req_tready;

   bsl_scanner u_scanner (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .text_byte   (req_tdata),
      .end_of_text (req_tlast),
      .push        (push)
   );

   bsl_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .head_valid (rsp_tvalid),
      .head_pop   (rsp_tready),
      .head       (head)
   );

   // pack the head item onto the result beat
   assign rsp_tdata = {6'd0, head.err, head.line, head.length, head.start};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule
